// ===== src/sitad_pkg.sv =====
`default_nettype none

package sitad_pkg;

    // defaults for the top-level parameters
    localparam int VALUE_BITS_DEF  = 32;
    localparam int DIGIT_SLOTS_DEF = 12;

    // longest text that leaves for one value
    localparam int MAX_CHARS = 11;

    // entries between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;

    // magnitude bits taken per double-dabble cycle
    localparam int BITS_PER_STEP = 4;

    typedef logic [6:0] ascii_t;

    localparam ascii_t ASCII_MINUS = 7'h2d;
    localparam ascii_t ASCII_ZERO  = 7'h30;

    localparam ascii_t LOWER_DIGITS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    localparam ascii_t UPPER_DIGITS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    typedef struct packed {
        logic signed [31:0] value;
        logic               radix_hex;
        logic               upper_case;
    } value_word_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last_char;
    } text_word_t;

    // per-item flags carried alongside the magnitude
    typedef struct packed {
        logic neg;
        logic radix_hex;
        logic upper_case;
    } item_flags_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_HOLD
    } conv_state_t;

    function automatic ascii_t digit_char(input logic [3:0] digit, input logic upper);
        return upper ? UPPER_DIGITS[digit] : LOWER_DIGITS[digit];
    endfunction

endpackage

`default_nettype wire

// ===== src/sitad_front.sv =====
`default_nettype none

module sitad_front #(
    parameter int VALUE_BITS = sitad_pkg::VALUE_BITS_DEF
) (
    input  sitad_pkg::value_word_t word,
    output logic [VALUE_BITS-1:0]  mag,
    output sitad_pkg::item_flags_t flags
);

    logic [VALUE_BITS-1:0] v;

    // sign-extend or truncate to the working width
    assign v = VALUE_BITS'(word.value);

    assign flags.neg        = v[VALUE_BITS-1];
    assign flags.radix_hex  = word.radix_hex;
    assign flags.upper_case = word.upper_case;

    // most negative value wraps to the unsigned 2^(n-1)
    assign mag = v[VALUE_BITS-1] ? ((~v) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;

endmodule

`default_nettype wire

// ===== src/sitad_queue.sv =====
`default_nettype none

module sitad_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sitad_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/sitad_conv.sv =====
`default_nettype none

module sitad_conv #(
    parameter int VALUE_BITS  = sitad_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_SLOTS = sitad_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [VALUE_BITS-1:0]    in_mag,
    input  sitad_pkg::item_flags_t   in_flags,
    output logic                     out_valid,
    input  logic                     out_take,
    output logic [4*DIGIT_SLOTS-1:0] out_digits,
    output sitad_pkg::item_flags_t   out_flags
);

    localparam int BPS   = sitad_pkg::BITS_PER_STEP;
    localparam int DW    = 4 * DIGIT_SLOTS;
    localparam int STEPS = (VALUE_BITS + BPS - 1) / BPS;
    localparam int SH_W  = STEPS * BPS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    sitad_pkg::conv_state_t state_reg, state_next;

    logic [DW-1:0]          bcd_reg, bcd_next;
    logic [SH_W-1:0]        sh_reg, sh_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    sitad_pkg::item_flags_t flags_reg, flags_next;
    logic [DW-1:0]          step_bcd;
    logic [SH_W-1:0]        step_sh;
    logic                   load;

    assign load = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sitad_pkg::CONV_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_flags.radix_hex ? sitad_pkg::CONV_HOLD : sitad_pkg::CONV_RUN;
                end
            end
            sitad_pkg::CONV_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = sitad_pkg::CONV_HOLD;
                end
            end
            sitad_pkg::CONV_HOLD:
            begin
                if (out_take)
                begin
                    if (in_valid)
                    begin
                        state_next = in_flags.radix_hex ? sitad_pkg::CONV_HOLD
                                                        : sitad_pkg::CONV_RUN;
                    end
                    else
                    begin
                        state_next = sitad_pkg::CONV_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sitad_pkg::CONV_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            sitad_pkg::CONV_IDLE:
            begin
                in_ready = 1'b1;
            end
            sitad_pkg::CONV_RUN:
            begin
                in_ready = 1'b0;
            end
            sitad_pkg::CONV_HOLD:
            begin
                out_valid = 1'b1;
                in_ready  = out_take;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_digits = bcd_reg;
    assign out_flags  = flags_reg;

    // double dabble, several magnitude bits per cycle; carries out of the
    // top digit drop, leaving the magnitude modulo 10^slots
    always_comb
    begin
        step_bcd = bcd_reg;
        step_sh  = sh_reg;
        for (int b = 0; b < BPS; b++)
        begin
            for (int d = 0; d < DIGIT_SLOTS; d++)
            begin
                if (step_bcd[4*d +: 4] >= 4'd5)
                begin
                    step_bcd[4*d +: 4] = step_bcd[4*d +: 4] + 4'd3;
                end
            end
            {step_bcd, step_sh} = {step_bcd[DW-2:0], step_sh, 1'b0};
        end
    end

    always_comb
    begin
        bcd_next   = bcd_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        if (load)
        begin
            flags_next = in_flags;
            cnt_next   = CNT_W'(STEPS - 1);
            sh_next    = SH_W'(in_mag);
            // hex digits are the low nibbles as they stand
            bcd_next   = in_flags.radix_hex ? DW'(in_mag) : '0;
        end
        else if (state_reg == sitad_pkg::CONV_RUN)
        begin
            bcd_next = step_bcd;
            sh_next  = step_sh;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitad_pkg::CONV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        sh_reg    <= sh_next;
        flags_reg <= flags_next;
    end

endmodule

`default_nettype wire

// ===== src/sitad_emit.sv =====
`default_nettype none

module sitad_emit #(
    parameter int DIGIT_SLOTS = sitad_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_take,
    input  logic [4*DIGIT_SLOTS-1:0] in_digits,
    input  sitad_pkg::item_flags_t   in_flags,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sitad_pkg::text_word_t    out_word
);

    localparam int DW    = 4 * DIGIT_SLOTS;
    localparam int IDX_W = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
    localparam int N_W   = (sitad_pkg::MAX_CHARS > 1) ? $clog2(sitad_pkg::MAX_CHARS) : 1;

    logic                  active_reg, active_next;
    logic                  sign_reg, sign_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [N_W-1:0]        n_reg, n_next;
    logic [DW-1:0]         digits_reg, digits_next;
    logic                  upper_reg, upper_next;
    logic                  out_valid_reg, out_valid_next;
    sitad_pkg::text_word_t out_word_reg, out_word_next;

    logic [IDX_W-1:0]  msd;
    logic              adv;
    sitad_pkg::ascii_t cur_char;
    logic              cur_last;

    // most significant non-zero digit; an all-zero value starts at the
    // lowest slot and gives a single zero
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < DIGIT_SLOTS; d++)
        begin
            if (in_digits[4*d +: 4] != 4'd0)
            begin
                msd = IDX_W'(d);
            end
        end
    end

    assign adv      = active_reg && (!out_valid_reg || out_ready);
    assign cur_char = sign_reg ? sitad_pkg::ASCII_MINUS
                               : sitad_pkg::digit_char(digits_reg[{idx_reg, 2'b00} +: 4],
                                                       upper_reg);
    assign cur_last = (!sign_reg && (idx_reg == '0))
                   || (n_reg == N_W'(sitad_pkg::MAX_CHARS - 1));
    assign in_take  = in_valid && (!active_reg || (adv && cur_last));

    always_comb
    begin
        active_next    = active_reg;
        sign_next      = sign_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        digits_next    = digits_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (adv)
        begin
            out_valid_next          = 1'b1;
            out_word_next.character = cur_char;
            out_word_next.last_char = cur_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_take)
        begin
            active_next = 1'b1;
            sign_next   = in_flags.neg;
            idx_next    = msd;
            n_next      = '0;
            digits_next = in_digits;
            upper_next  = in_flags.upper_case;
        end
        else if (adv)
        begin
            n_next = n_reg + 1'b1;
            if (cur_last)
            begin
                active_next = 1'b0;
            end
            else if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg     <= sign_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        digits_reg   <= digits_next;
        upper_reg    <= upper_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

// ===== src/signed_int_to_ascii_digits.sv =====
`default_nettype none

// Signed integer to ASCII text. Each word on the value channel carries a
// 32-bit two's complement value, a radix select (decimal or hexadecimal)
// and a letter-case select for hex digits. Its text leaves on the text
// channel one character per word, most significant first: a '-' for a
// negative value (in hex too), then the magnitude with leading zeros
// suppressed, or a single '0' for zero; last_char marks the final
// character. The most negative value reads as the unsigned magnitude
// 2^(VALUE_BITS-1). Only the DIGIT_SLOTS lowest digits are formed and at
// most 11 characters leave per value. The front classifies the value
// (sign, magnitude) into a two-entry queue; the back converts it with a
// double-dabble unit that takes 4 magnitude bits a cycle and hands the
// digits to a character sequencer with a registered output. Conversion
// loads the magnitude and then runs the double-dabble steps in decimal;
// in hex it skips them. The sequencer sends a value's characters one per
// cycle while the text channel is ready, overlapping with the next
// conversion. Between acceptance and the first character a value passes
// the queue, the converter and the sequencer's output register.
// There is no configuration and no state kept across values.

module signed_int_to_ascii_digits #(
    parameter int VALUE_BITS  = sitad_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_SLOTS = sitad_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    output logic                  value_ready,
    input  sitad_pkg::value_word_t value_word,
    output logic                  text_valid,
    input  logic                  text_ready,
    output sitad_pkg::text_word_t text_word
);

    localparam int FLAG_W = $bits(sitad_pkg::item_flags_t);
    localparam int ENT_W  = VALUE_BITS + FLAG_W;
    localparam int DW     = 4 * DIGIT_SLOTS;

    // front: sign and magnitude
    logic [VALUE_BITS-1:0]  front_mag;
    sitad_pkg::item_flags_t front_flags;

    // queue between front and back
    logic                   q_pop_valid;
    logic                   q_pop_ready;
    logic [ENT_W-1:0]       q_pop_data;
    logic [VALUE_BITS-1:0]  q_mag;
    sitad_pkg::item_flags_t q_flags;

    // converter to sequencer handoff
    logic                   conv_valid;
    logic                   conv_take;
    logic [DW-1:0]          conv_digits;
    sitad_pkg::item_flags_t conv_flags;

    sitad_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .word  (value_word),
        .mag   (front_mag),
        .flags (front_flags)
    );

    sitad_queue #(
        .WIDTH (ENT_W),
        .DEPTH (sitad_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (value_valid),
        .push_ready (value_ready),
        .push_data  ({front_mag, front_flags}),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    assign q_mag   = q_pop_data[ENT_W-1:FLAG_W];
    assign q_flags = sitad_pkg::item_flags_t'(q_pop_data[FLAG_W-1:0]);

    // back, first half: digit conversion
    sitad_conv #(
        .VALUE_BITS  (VALUE_BITS),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_pop_valid),
        .in_ready   (q_pop_ready),
        .in_mag     (q_mag),
        .in_flags   (q_flags),
        .out_valid  (conv_valid),
        .out_take   (conv_take),
        .out_digits (conv_digits),
        .out_flags  (conv_flags)
    );

    // back, second half: one character per cycle while the text channel is ready
    sitad_emit #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (conv_valid),
        .in_take   (conv_take),
        .in_digits (conv_digits),
        .in_flags  (conv_flags),
        .out_valid (text_valid),
        .out_ready (text_ready),
        .out_word  (text_word)
    );

    // converted digits must hold until the sequencer takes them
    a_conv_hold : assert property (@(posedge clk) disable iff (!rst_n)
        conv_valid && !conv_take |=> conv_valid && $stable(conv_digits)
                                     && $stable(conv_flags))
        else $error("converter result changed before handoff");

    // an accepted value leaves the queue non-empty on the next cycle
    a_queue_fill : assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_ready |=> q_pop_valid)
        else $error("queue lost an accepted value");

    // a minus sign is always followed by at least one digit
    a_minus_not_last : assert property (@(posedge clk) disable iff (!rst_n)
        text_valid |-> !(text_word.character == sitad_pkg::ASCII_MINUS
                         && text_word.last_char))
        else $error("text ended on a minus sign");

endmodule

`default_nettype wire
